@@ rtl/graph_reachability_search_defines.svh @@
// Assertion macros used by the port-level checker of the reachability search block.
`ifndef GRAPH_REACHABILITY_SEARCH_DEFINES_SVH
`define GRAPH_REACHABILITY_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/grs_pkg.sv @@
// Shared constants, codes and types of the reachability search block.
`default_nettype none
package grs_pkg;

    localparam int VERTICES = 64;
    localparam int EDGES    = 1024;

    localparam int OP_W   = 2;
    localparam int VTX_W  = 7;
    localparam int WGT_W  = 16;
    localparam int ST_W   = 3;

    localparam int VIDX_W  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int EA_W    = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int ECNT_W  = $clog2(EDGES + 1);
    localparam int DEPTH_W = $clog2(VERTICES + 1);
    localparam int EDGE_W  = 2 * VTX_W + 1;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
    localparam logic [ST_W-1:0] ST_REACH = 3'd3;
    localparam logic [ST_W-1:0] ST_NONE  = 3'd4;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VTX_W-1:0] vertex;
        logic             last;
    } grs_result_t;

    typedef struct packed {
        logic [VTX_W-1:0] from_v;
        logic [VTX_W-1:0] to_v;
        logic             enabled;
    } grs_edge_t;

    // A vertex id is usable when it lies in 1..VERTICES.
    function automatic logic vertex_ok(input logic [VTX_W-1:0] v);
        return (v != '0) && (v <= VTX_W'(VERTICES));
    endfunction

endpackage
`default_nettype wire

@@ rtl/grs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module grs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/grs_out.sv @@
// Output register stage that holds one result until the consumer takes it.
`default_nettype none
module grs_out (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  grs_pkg::grs_result_t     load_data,
    output logic                     free,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic [grs_pkg::ST_W-1:0] status,
    output logic [grs_pkg::VTX_W-1:0] vertex_out,
    output logic                     last
);
    import grs_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    grs_result_t data_reg;

    // The stage can take a new result when empty or when its result leaves now.
    assign free = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign rsp_valid  = valid_reg;
    assign status     = data_reg.status;
    assign vertex_out = data_reg.vertex;
    assign last       = data_reg.last;

endmodule
`default_nettype wire

@@ rtl/graph_reachability_search.sv @@
// Top level: edge table, search stack and the depth-first search sequencer.
//
// Loads, clears and queries with an unusable source each give one result; the spare
// opcode gives none. A query pushes the source, then for each vertex popped from the
// stack passes the pop and fetch states and checks every stored edge, because the whole
// edge table is scanned through its single read port for every popped vertex. A sweep
// of the visited map then emits the reachable vertices other than the source in
// ascending order; if none is reached, one no-path result is given. The request side is
// not ready until the last result of a query has been handed to the output register.
// No clearing pass is needed after reset.
`default_nettype none
module graph_reachability_search (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [grs_pkg::OP_W-1:0]   opcode,
    input  logic [grs_pkg::VTX_W-1:0]  from_vertex,
    input  logic [grs_pkg::VTX_W-1:0]  to_vertex,
    input  logic [grs_pkg::WGT_W-1:0]  edge_weight,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic [grs_pkg::ST_W-1:0]   status,
    output logic [grs_pkg::VTX_W-1:0]  vertex_out,
    output logic                       last
);
    import grs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_NONE  = 3'd5;

    logic [2:0]          state_reg,  state_next;
    logic [ECNT_W-1:0]   count_reg,  count_next;
    logic [DEPTH_W-1:0]  depth_reg,  depth_next;
    logic [DEPTH_W-1:0]  found_reg,  found_next;
    logic [VERTICES-1:0] visited_reg, visited_next;
    logic [VTX_W-1:0]    src_reg,    src_next;
    logic [VTX_W-1:0]    cur_reg,    cur_next;
    logic [ECNT_W-1:0]   scan_reg,   scan_next;
    logic [VTX_W-1:0]    emit_reg,   emit_next;

    logic                out_free;
    logic                out_load;
    grs_result_t         out_data;
    logic                accept;

    logic                edge_we;
    grs_edge_t           edge_wdata;
    grs_edge_t           edge_rdata;
    logic [EA_W-1:0]     edge_raddr;
    logic                stk_we;
    logic [VTX_W-1:0]    stk_wdata;
    logic [VIDX_W-1:0]   stk_raddr;
    logic [VTX_W-1:0]    stk_rdata;
    logic [DEPTH_W-1:0]  depth_dec;
    logic [VIDX_W-1:0]   src_idx;
    logic [VIDX_W-1:0]   to_idx;
    logic [VIDX_W-1:0]   emit_idx;
    logic                edge_hit;
    logic                emit_hit;

    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;

    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign src_idx   = VIDX_W'(from_vertex - VTX_W'(1));
    assign to_idx    = VIDX_W'(edge_rdata.to_v - VTX_W'(1));
    assign emit_idx  = VIDX_W'(emit_reg - VTX_W'(1));

    // Edge compare: an enabled link from the popped vertex to an unvisited vertex.
    assign edge_hit = edge_rdata.enabled && (edge_rdata.from_v == cur_reg)
                      && !visited_reg[to_idx];
    assign emit_hit = visited_reg[emit_idx] && (emit_reg != src_reg);

    assign edge_wdata.from_v  = from_vertex;
    assign edge_wdata.to_v    = to_vertex;
    assign edge_wdata.enabled = (edge_weight == WGT_W'(1));
    assign edge_raddr         = scan_reg[EA_W-1:0];
    assign stk_raddr          = depth_dec[VIDX_W-1:0];
    assign stk_wdata          = (state_reg == S_IDLE) ? from_vertex : edge_rdata.to_v;

    // Sequencer and search datapath.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        depth_next   = depth_reg;
        found_next   = found_reg;
        visited_next = visited_reg;
        src_next     = src_reg;
        cur_next     = cur_reg;
        scan_next    = scan_reg;
        emit_next    = emit_reg;
        edge_we      = 1'b0;
        stk_we       = 1'b0;
        out_load     = 1'b0;
        out_data     = '{status: ST_OK, vertex: '0, last: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_LOAD:
                        begin
                            out_load = 1'b1;
                            if (!vertex_ok(from_vertex) || !vertex_ok(to_vertex))
                            begin
                                out_data.status = ST_BAD;
                            end
                            else if (count_reg == ECNT_W'(EDGES))
                            begin
                                out_data.status = ST_FULL;
                            end
                            else
                            begin
                                edge_we    = 1'b1;
                                count_next = count_reg + ECNT_W'(1);
                            end
                        end
                        OP_QUERY:
                        begin
                            if (!vertex_ok(from_vertex))
                            begin
                                out_load        = 1'b1;
                                out_data.status = ST_NONE;
                            end
                            else
                            begin
                                visited_next          = '0;
                                visited_next[src_idx] = 1'b1;
                                stk_we                = 1'b1;
                                depth_next            = DEPTH_W'(1);
                                found_next            = '0;
                                src_next              = from_vertex;
                                state_next            = S_POP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            out_load   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP:
            begin
                scan_next = '0;
                if (depth_reg == '0)
                begin
                    emit_next  = VTX_W'(1);
                    state_next = (found_reg == '0) ? S_NONE : S_EMIT;
                end
                else
                begin
                    depth_next = depth_dec;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cur_next = stk_rdata;
                if (count_reg == '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    scan_next  = ECNT_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (edge_hit)
                begin
                    visited_next[to_idx] = 1'b1;
                    stk_we               = 1'b1;
                    depth_next           = depth_reg + DEPTH_W'(1);
                    found_next           = found_reg + DEPTH_W'(1);
                end
                if (scan_reg == count_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    scan_next = scan_reg + ECNT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit_next = emit_reg + VTX_W'(1);
                    if (emit_hit)
                    begin
                        out_load        = 1'b1;
                        out_data.status = ST_REACH;
                        out_data.vertex = emit_reg;
                        out_data.last   = (found_reg == DEPTH_W'(1));
                        found_next      = found_reg - DEPTH_W'(1);
                        if (found_reg == DEPTH_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_NONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_data.status = ST_NONE;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            depth_reg   <= '0;
            found_reg   <= '0;
            visited_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            depth_reg   <= depth_next;
            found_reg   <= found_next;
            visited_reg <= visited_next;
        end
    end

    // Search payload registers.
    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        cur_reg  <= cur_next;
        scan_reg <= scan_next;
        emit_reg <= emit_next;
    end

    // Edge table.
    grs_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (count_reg[EA_W-1:0]),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // Search stack.
    grs_ram #(
        .WIDTH (VTX_W),
        .DEPTH (VERTICES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_reg[VIDX_W-1:0]),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Result register.
    grs_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .load_data  (out_data),
        .free       (out_free),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .vertex_out (vertex_out),
        .last       (last)
    );

endmodule
`default_nettype wire

@@ rtl/grs_checker.sv @@
// Port-level checker for the reachability search block and its bind.
`default_nettype none
`include "graph_reachability_search_defines.svh"
module grs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [grs_pkg::ST_W-1:0]   status,
    input logic [grs_pkg::VTX_W-1:0]  vertex_out,
    input logic                       last
);
    import grs_pkg::*;

    // A stalled result stays offered.
    `GRS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `GRS_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(status) && $stable(vertex_out) && $stable(last), "result changed while stalled")

    // A new request is only taken when the result register can accept its answer.
    `GRS_ASSERT_NOW(a_req_gate, clk, rst_n, req_ready, !rsp_valid || rsp_ready, "request taken with result register blocked")

    // Only reachable-vertex results carry a vertex id.
    `GRS_ASSERT_NOW(a_vertex_code, clk, rst_n, rsp_valid, (status == ST_REACH) == (vertex_out != '0), "vertex id does not match status")

    // Every single-result answer closes its request.
    `GRS_ASSERT_NOW(a_single_last, clk, rst_n, rsp_valid && (status != ST_REACH), last, "single result without last flag")

endmodule

bind graph_reachability_search grs_checker u_grs_checker (.*);
`default_nettype wire

@@ tb/sv/reachability_checker.sv @@
// Checker for the reachability search block: watches both channels, predicts and compares.
module reachability_checker
    import grs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  logic [OP_W-1:0]  opcode,
    input  logic [VTX_W-1:0] from_vertex,
    input  logic [VTX_W-1:0] to_vertex,
    input  logic [WGT_W-1:0] edge_weight,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  logic [ST_W-1:0]  status,
    input  logic [VTX_W-1:0] vertex_out,
    input  logic             last,
    output int               mismatches,
    output int               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Private copy of the edge table as the block should hold it.
    logic [VTX_W-1:0] tbl_from [EDGES];
    logic [VTX_W-1:0] tbl_to   [EDGES];
    logic             tbl_link [EDGES];
    int               edge_total = 0;

    // Responses still owed by the block, oldest first.
    grs_result_t awaited_results [$];

    int mismatch_total = 0;
    int response_index = 0;

    assign mismatches = mismatch_total;

    // Prints one line per mismatch (the first hundred only) and counts all of them.
    task automatic report_mismatch(input string what);
        if (mismatch_total < 100)
        begin
            $display("MISMATCH @%0t response %0d: %s", $time, response_index, what);
        end
        mismatch_total++;
    endtask

    function automatic logic in_vertex_range(input logic [VTX_W-1:0] v);
        return (v >= VTX_W'(1)) && (v <= VTX_W'(VERTICES));
    endfunction

    task automatic expect_single(input logic [ST_W-1:0] st);
        awaited_results.push_back(grs_result_t'{status: st, vertex: '0, last: 1'b1});
    endtask

    // Depth-first walk over weight-one edges, then an ascending sweep of the visited map.
    task automatic search_reachable(input logic [VTX_W-1:0] src);
        bit               seen [VERTICES + 1];
        logic [VTX_W-1:0] stack [VERTICES];
        logic [VTX_W-1:0] cur;
        logic [VTX_W-1:0] reached [$];
        int               depth;
        if (!in_vertex_range(src))
        begin
            expect_single(ST_NONE);
            return;
        end
        foreach (seen[v])
        begin
            seen[v] = 1'b0;
        end
        seen[src] = 1'b1;
        stack[0]  = src;
        depth     = 1;
        while (depth > 0)
        begin
            depth--;
            cur = stack[depth];
            for (int i = 0; i < edge_total; i++)
            begin
                if (tbl_link[i] && tbl_from[i] == cur && !seen[tbl_to[i]])
                begin
                    seen[tbl_to[i]] = 1'b1;
                    stack[depth]    = tbl_to[i];
                    depth++;
                end
            end
        end
        for (int v = 1; v <= VERTICES; v++)
        begin
            if (seen[v] && VTX_W'(v) != src)
            begin
                reached.push_back(VTX_W'(v));
            end
        end
        if (reached.size() == 0)
        begin
            expect_single(ST_NONE);
        end
        else
        begin
            foreach (reached[k])
            begin
                awaited_results.push_back(grs_result_t'{status: ST_REACH, vertex: reached[k],
                                                        last: (k == reached.size() - 1)});
            end
        end
    endtask

    // Updates the table copy and queues the responses one request should cause.
    task automatic predict_request(input logic [OP_W-1:0]  op,
                                   input logic [VTX_W-1:0] fv,
                                   input logic [VTX_W-1:0] tv,
                                   input logic [WGT_W-1:0] w);
        case (op)
            OP_LOAD:
            begin
                if (!in_vertex_range(fv) || !in_vertex_range(tv))
                begin
                    expect_single(ST_BAD);
                end
                else if (edge_total >= EDGES)
                begin
                    expect_single(ST_FULL);
                end
                else
                begin
                    tbl_from[edge_total] = fv;
                    tbl_to[edge_total]   = tv;
                    tbl_link[edge_total] = (w == WGT_W'(1));
                    edge_total++;
                    expect_single(ST_OK);
                end
            end
            OP_QUERY:
            begin
                search_reachable(fv);
            end
            OP_CLEAR:
            begin
                edge_total = 0;
                expect_single(ST_OK);
            end
            default:
            begin
                // The spare opcode is ignored and owes nothing.
            end
        endcase
    endtask

    // Sample both handshakes at each rising edge.
    always @(posedge clk)
    begin
        grs_result_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                predict_request(opcode, from_vertex, to_vertex, edge_weight);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected response status %0d vertex %0d last %0d",
                                              status, vertex_out, last));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status != want.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    end
                    if (vertex_out != want.vertex)
                    begin
                        report_mismatch($sformatf("vertex_out %0d, expected %0d",
                                                  vertex_out, want.vertex));
                    end
                    if (last != want.last)
                    begin
                        report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
                    end
                end
                response_index++;
            end
        end
        pending_results <= awaited_results.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// Top of the reachability search testbench: clock, reset, request stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import grs_pkg::*;

    // The fourth opcode value has no meaning and must be ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    logic [OP_W-1:0]  opcode;
    logic [VTX_W-1:0] from_vertex;
    logic [VTX_W-1:0] to_vertex;
    logic [WGT_W-1:0] edge_weight;
    logic             rsp_valid;
    logic             rsp_ready;
    logic [ST_W-1:0]  status;
    logic [VTX_W-1:0] vertex_out;
    logic             last;

    int mismatches;
    int pending_results;

    int burst_left;
    int items_sent;
    int edges_held;
    int pool_lo;
    int pool_size;

    always #5 clk = ~clk;

    graph_reachability_search i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .opcode      (opcode),
        .from_vertex (from_vertex),
        .to_vertex   (to_vertex),
        .edge_weight (edge_weight),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .vertex_out  (vertex_out),
        .last        (last)
    );

    reachability_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .opcode          (opcode),
        .from_vertex     (from_vertex),
        .to_vertex       (to_vertex),
        .edge_weight     (edge_weight),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .status          (status),
        .vertex_out      (vertex_out),
        .last            (last),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // Mostly short bursts, now and then a long stretch with no gaps at all.
    function automatic int new_burst();
        if ($urandom_range(0, 5) == 0)
        begin
            return int'($urandom_range(30, 80));
        end
        return int'($urandom_range(1, 10));
    endfunction

    // A vertex id of 0 or above the vertex bound.
    function automatic logic [VTX_W-1:0] bad_vertex();
        if ($urandom_range(0, 3) == 0)
        begin
            return '0;
        end
        return VTX_W'($urandom_range(VERTICES + 1, 127));
    endfunction

    // A vertex from the window the current random graph lives in.
    function automatic logic [VTX_W-1:0] pool_vertex();
        return VTX_W'(pool_lo + int'($urandom_range(0, pool_size - 1)));
    endfunction

    // Presents one request, holds it until accepted, then maybe opens a gap.
    task automatic issue(input logic [OP_W-1:0]  op,
                         input logic [VTX_W-1:0] fv,
                         input logic [VTX_W-1:0] tv,
                         input logic [WGT_W-1:0] w);
        req_valid   <= 1'b1;
        opcode      <= op;
        from_vertex <= fv;
        to_vertex   <= tv;
        edge_weight <= w;
        do
            @(posedge clk);
        while (!req_ready);
        if (op != OP_UNUSED)
        begin
            items_sent++;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = new_burst();
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic query(input logic [VTX_W-1:0] src);
        issue(OP_QUERY, src, VTX_W'($urandom), WGT_W'($urandom));
    endtask

    task automatic clear_table();
        issue(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom));
    endtask

    // Holds off new requests until every owed response has been taken.
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        burst_left = new_burst();
    endtask

    // Response side: alternates between always ready, coin flips and long stalls.
    initial
    begin
        int mode;
        int span;
        rsp_ready <= 1'b0;
        forever
        begin
            mode = int'($urandom_range(0, 2));
            span = int'($urandom_range(10, 120));
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Request stimulus and verdict.
    initial
    begin
        int               n_edges;
        logic [VTX_W-1:0] fv;
        logic [VTX_W-1:0] tv;
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        opcode      <= OP_LOAD;
        from_vertex <= '0;
        to_vertex   <= '0;
        edge_weight <= '0;
        burst_left  = new_burst();
        items_sent  = 0;
        edges_held  = 0;
        pool_lo     = 1;
        pool_size   = VERTICES;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, bad endpoints, self loop, cycle back, non-unit weights.
        query(7'd1);
        issue(OP_LOAD, 7'd0, 7'd5, 16'd1);
        issue(OP_LOAD, 7'd5, 7'd0, 16'd1);
        issue(OP_LOAD, 7'd65, 7'd3, 16'd1);
        issue(OP_LOAD, 7'd3, 7'd127, 16'd1);
        issue(OP_LOAD, 7'd1, 7'd64, 16'd1);
        issue(OP_LOAD, 7'd64, 7'd2, 16'd1);
        issue(OP_LOAD, 7'd2, 7'd2, 16'd1);
        issue(OP_LOAD, 7'd2, 7'd1, 16'd1);
        issue(OP_LOAD, 7'd2, 7'd3, 16'hFFFF);
        issue(OP_LOAD, 7'd2, 7'd4, 16'd0);
        issue(OP_LOAD, 7'd3, 7'd4, 16'd1);
        query(7'd1);
        query(7'd64);
        query(7'd0);
        query(7'd127);
        query(7'd3);
        query(7'd4);
        issue(OP_UNUSED, 7'd1, 7'd2, 16'd1);
        clear_table();
        query(7'd1);
        drain();

        // Fill the table to capacity, then push past it.
        clear_table();
        for (int i = 0; i < EDGES; i++)
        begin
            if (i < 12)
            begin
                issue(OP_LOAD, VTX_W'(20 + i), VTX_W'(21 + i), 16'd1);
            end
            else
            begin
                issue(OP_LOAD, VTX_W'($urandom_range(1, VERTICES)),
                      VTX_W'($urandom_range(1, VERTICES)),
                      ($urandom_range(0, 99) == 0) ? 16'd1 : WGT_W'($urandom));
            end
        end
        issue(OP_LOAD, 7'd1, 7'd2, 16'd1);
        issue(OP_LOAD, 7'd0, 7'd2, 16'd1);
        issue(OP_LOAD, 7'd64, 7'd64, 16'd3);
        query(7'd20);
        drain();
        clear_table();

        // Random graphs: load a batch of edges over a vertex window, then query it.
        items_sent = 0;
        while (items_sent < 260)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain();
            end
            if (edges_held > 120 || $urandom_range(0, 3) != 0)
            begin
                clear_table();
                edges_held = 0;
            end
            pool_size = ($urandom_range(0, 3) == 0) ? VERTICES : int'($urandom_range(2, 16));
            pool_lo   = int'($urandom_range(1, VERTICES + 1 - pool_size));
            n_edges   = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 90))
                                                    : int'($urandom_range(2, 20));
            repeat (n_edges)
            begin
                case ($urandom_range(0, 15))
                    0:
                    begin
                        issue(OP_LOAD, bad_vertex(), pool_vertex(), WGT_W'($urandom));
                    end
                    1:
                    begin
                        issue(OP_LOAD, pool_vertex(), bad_vertex(), 16'd1);
                    end
                    2:
                    begin
                        issue(OP_UNUSED, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom));
                    end
                    default:
                    begin
                        fv = pool_vertex();
                        tv = pool_vertex();
                        issue(OP_LOAD, fv, tv,
                              ($urandom_range(0, 3) == 0) ? WGT_W'($urandom) : 16'd1);
                        edges_held++;
                    end
                endcase
            end
            repeat ($urandom_range(1, 5))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    query(VTX_W'($urandom));
                end
                else
                begin
                    query(pool_vertex());
                end
            end
        end

        // Let everything owed arrive, then watch a while for strays.
        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog against a hung handshake or responses that never come.
    initial
    begin
        #(40_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/grs_pkg.sv
rtl/grs_ram.sv
rtl/grs_out.sv
rtl/graph_reachability_search.sv
rtl/grs_checker.sv
tb/sv/reachability_checker.sv
tb/sv/tb.sv
